// File: rtl/csfp_pkg.sv
// ----------------------------------------------------------------------------
// csfp_pkg
// Shared constants and types of the checksum frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package csfp_pkg;

  localparam logic [7:0] SyncFirst   = 8'hEB;
  localparam logic [7:0] SyncSecond  = 8'h90;
  localparam logic [7:0] EnableOn    = 8'hF0;

  localparam int unsigned PosW       = 4;
  localparam logic [PosW-1:0] PosHunt     = 4'd0;
  localparam logic [PosW-1:0] PosSync2    = 4'd1;
  localparam logic [PosW-1:0] PosCounter  = 4'd2;
  localparam logic [PosW-1:0] PosEnable   = 4'd3;
  localparam logic [PosW-1:0] PosPosLo    = 4'd4;
  localparam logic [PosW-1:0] PosPosHi    = 4'd5;
  localparam logic [PosW-1:0] PosTail     = 4'd6;
  localparam logic [PosW-1:0] LastPayload = 4'd11;
  localparam logic [PosW-1:0] PosCheck    = 4'd12;
  localparam logic [PosW-1:0] FrameLen    = 4'd13;

  localparam int unsigned TailDepth  = 6;
  localparam int unsigned TailIdxW   = 3;

  typedef struct packed {
    logic        byte_accepted;
    logic        frame_done;
    logic [3:0]  bytes_needed;
    logic [7:0]  frame_counter;
    logic        drive_enable;
    logic [15:0] target_position;
    logic [7:0]  extra_byte6;
    logic [7:0]  extra_byte7;
    logic [7:0]  extra_byte8;
    logic [7:0]  extra_byte9;
    logic [7:0]  extra_byte10;
    logic [7:0]  extra_byte11;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/csfp_tracker.sv
// ----------------------------------------------------------------------------
// csfp_tracker
// Frame position, running checksum and field stores; forms one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module csfp_tracker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              covers_last_i,
  output csfp_pkg::result_t      res_o
);

  logic [csfp_pkg::PosW-1:0] pos_q, pos_d, pos;
  logic [7:0]                sum_q, sum_d;
  logic [7:0]                counter_q, counter_d;
  logic                      enable_q, enable_d;
  logic [15:0]               position_q, position_d;
  logic [7:0]                tail_q [csfp_pkg::TailDepth];
  logic [7:0]                tail_d [csfp_pkg::TailDepth];
  logic [csfp_pkg::PosW-1:0] tail_off;
  logic [csfp_pkg::TailIdxW-1:0] tail_idx;
  logic                      accepted;
  logic                      done;

  assign tail_off = pos - csfp_pkg::PosTail;
  assign tail_idx = tail_off[csfp_pkg::TailIdxW-1:0];

  always_comb begin
    pos        = (pos_q > csfp_pkg::PosCheck) ? csfp_pkg::PosHunt : pos_q;
    pos_d      = pos;
    sum_d      = sum_q;
    counter_d  = counter_q;
    enable_d   = enable_q;
    position_d = position_q;
    tail_d     = tail_q;
    accepted   = 1'b0;
    done       = 1'b0;

    if (pos == csfp_pkg::PosHunt) begin
      if (rx_byte_i == csfp_pkg::SyncFirst) begin
        accepted = 1'b1;
        sum_d    = 8'd0;
        pos_d    = csfp_pkg::PosSync2;
      end else begin
        pos_d    = csfp_pkg::PosHunt;
      end
    end else if (pos == csfp_pkg::PosSync2) begin
      if (rx_byte_i == csfp_pkg::SyncSecond) begin
        accepted = 1'b1;
        pos_d    = csfp_pkg::PosCounter;
      end else begin
        // drop the partial frame; a fresh first sync restarts it
        sum_d = 8'd0;
        pos_d = (rx_byte_i == csfp_pkg::SyncFirst) ? csfp_pkg::PosSync2
                                                   : csfp_pkg::PosHunt;
      end
    end else if (pos <= csfp_pkg::LastPayload) begin
      accepted = 1'b1;
      if (pos < csfp_pkg::LastPayload || covers_last_i) begin
        sum_d = sum_q + rx_byte_i;
      end
      case (pos)
        csfp_pkg::PosCounter: counter_d = rx_byte_i;
        csfp_pkg::PosEnable:  enable_d = (rx_byte_i == csfp_pkg::EnableOn);
        csfp_pkg::PosPosLo:   position_d[7:0] = rx_byte_i;
        csfp_pkg::PosPosHi:   position_d[15:8] = rx_byte_i;
        default:              tail_d[tail_idx] = rx_byte_i;
      endcase
      pos_d = pos + 4'd1;
    end else begin
      if (rx_byte_i == sum_q) begin
        accepted = 1'b1;
        done     = 1'b1;
        sum_d    = 8'd0;
        pos_d    = csfp_pkg::PosHunt;
      end else begin
        sum_d = 8'd0;
        pos_d = (rx_byte_i == csfp_pkg::SyncFirst) ? csfp_pkg::PosSync2
                                                   : csfp_pkg::PosHunt;
      end
    end
  end

  always_comb begin
    res_o                 = '0;
    res_o.byte_accepted   = accepted;
    res_o.frame_done      = done;
    res_o.bytes_needed    = csfp_pkg::FrameLen - pos_d;
    if (done) begin
      res_o.frame_counter   = counter_q;
      res_o.drive_enable    = enable_q;
      res_o.target_position = position_q;
      res_o.extra_byte6     = tail_q[0];
      res_o.extra_byte7     = tail_q[1];
      res_o.extra_byte8     = tail_q[2];
      res_o.extra_byte9     = tail_q[3];
      res_o.extra_byte10    = tail_q[4];
      res_o.extra_byte11    = tail_q[5];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= csfp_pkg::PosHunt;
      sum_q <= 8'd0;
    end else if (take_i) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      counter_q  <= counter_d;
      enable_q   <= enable_d;
      position_q <= position_d;
      tail_q     <= tail_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/csfp_out_reg.sv
// ----------------------------------------------------------------------------
// csfp_out_reg
// Result register between the parser and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module csfp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  csfp_pkg::result_t      res_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output csfp_pkg::result_t      res_o
);

  logic              valid_q, valid_d;
  csfp_pkg::result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// File: rtl/sync_checksum_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_checksum_frame_parser
// Hunts for 13-byte frames (EB 90, ten payload bytes, 8-bit sum) in a byte
// stream and reports, for every byte, whether it fitted and what it decoded.
//
// Input channel: rx_byte_i with in_valid_i; a transfer happens when
// in_valid_i is high and in_stall_o is low. Output channel: one result per
// input byte on the *_o field ports, transferred when out_valid_o is high
// and out_stall_i is low.
// The result of a byte is on the outputs in the cycle after its transfer.
// Throughput is one byte per cycle while in_stall_o is low, set by the single
// result register; the frame position and running sum update on each transfer.
// in_stall_o rises only while a result is held back by out_stall_i; the
// held result stays unchanged until taken.
// Reset empties the result register, clears the checksum-range bit and
// returns the parser to hunting for the first sync byte.
// cfg_we_i/cfg_wdata_i write the checksum range bit: 0 sums bytes 2..10,
// 1 sums bytes 2..11. It is sampled when byte 11 arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_checksum_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             byte_accepted_o,
  output logic             frame_done_o,
  output logic [3:0]       bytes_needed_o,
  output logic [7:0]       frame_counter_o,
  output logic             drive_enable_o,
  output logic [15:0]      target_position_o,
  output logic [7:0]       extra_byte6_o,
  output logic [7:0]       extra_byte7_o,
  output logic [7:0]       extra_byte8_o,
  output logic [7:0]       extra_byte9_o,
  output logic [7:0]       extra_byte10_o,
  output logic [7:0]       extra_byte11_o
);

  logic              covers_last_q;
  logic              take;
  csfp_pkg::result_t res;
  csfp_pkg::result_t res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      covers_last_q <= 1'b0;
    end else if (cfg_we_i) begin
      covers_last_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = out_valid_o & out_stall_i;
  assign take       = in_valid_i & ~in_stall_o;

  csfp_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .rx_byte_i     (rx_byte_i),
    .covers_last_i (covers_last_q),
    .res_o         (res)
  );

  csfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign byte_accepted_o   = res_out.byte_accepted;
  assign frame_done_o      = res_out.frame_done;
  assign bytes_needed_o    = res_out.bytes_needed;
  assign frame_counter_o   = res_out.frame_counter;
  assign drive_enable_o    = res_out.drive_enable;
  assign target_position_o = res_out.target_position;
  assign extra_byte6_o     = res_out.extra_byte6;
  assign extra_byte7_o     = res_out.extra_byte7;
  assign extra_byte8_o     = res_out.extra_byte8;
  assign extra_byte9_o     = res_out.extra_byte9;
  assign extra_byte10_o    = res_out.extra_byte10;
  assign extra_byte11_o    = res_out.extra_byte11;

endmodule

`default_nettype wire

// File: rtl/csfp_checker.sv
// ----------------------------------------------------------------------------
// csfp_checker
// Port-level checks on the frame parser, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module csfp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic        byte_accepted_i,
  input  wire logic        frame_done_i,
  input  wire logic [3:0]  bytes_needed_i,
  input  wire logic [7:0]  frame_counter_i,
  input  wire logic        drive_enable_i,
  input  wire logic [15:0] target_position_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_done_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> byte_accepted_i)
    else $error("frame done on a rejected byte");

  a_done_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> bytes_needed_i == csfp_pkg::FrameLen)
    else $error("hunting not restarted after a frame");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_done_i |->
      frame_counter_i == 8'd0 && !drive_enable_i && target_position_i == 16'd0)
    else $error("frame fields set without a finished frame");

  a_reject_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_accepted_i |->
      bytes_needed_i == csfp_pkg::FrameLen || bytes_needed_i == 4'd12)
    else $error("rejected byte left a partial frame");

endmodule

bind sync_checksum_frame_parser csfp_checker u_csfp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .byte_accepted_i   (byte_accepted_o),
  .frame_done_i      (frame_done_o),
  .bytes_needed_i    (bytes_needed_o),
  .frame_counter_i   (frame_counter_o),
  .drive_enable_i    (drive_enable_o),
  .target_position_i (target_position_o)
);

`default_nettype wire

// File: bench/sync_checksum_frame_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_checksum_frame_parser_checker
// Watches both channels and the checksum-range register of the frame parser.
// Every byte transfer is run through its own copy of the parser state to
// predict the result that the block must return for it. Every result
// transfer is compared field by field with the oldest prediction. Failures
// and the number of outstanding predictions are passed to the top.
// ----------------------------------------------------------------------------

module sync_checksum_frame_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        byte_accepted_i,
  input  logic        frame_done_i,
  input  logic [3:0]  bytes_needed_i,
  input  logic [7:0]  frame_counter_i,
  input  logic        drive_enable_i,
  input  logic [15:0] target_position_i,
  input  logic [7:0]  extra_byte6_i,
  input  logic [7:0]  extra_byte7_i,
  input  logic [7:0]  extra_byte8_i,
  input  logic [7:0]  extra_byte9_i,
  input  logic [7:0]  extra_byte10_i,
  input  logic [7:0]  extra_byte11_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int ExpDepth = 16;

  logic                        covers_last;
  logic [csfp_pkg::PosW-1:0]   frame_pos;
  logic [7:0]                  byte_sum;
  logic [7:0]                  seq_counter;
  logic [7:0]                  enable_byte;
  logic [15:0]                 target_pos;
  logic [7:0]                  tail_bytes [csfp_pkg::TailDepth];

  csfp_pkg::result_t           expected_mem [ExpDepth];
  logic [3:0]                  exp_wr;
  logic [3:0]                  exp_rd;
  int                          exp_count;
  csfp_pkg::result_t           got;
  csfp_pkg::result_t           want;
  csfp_pkg::result_t           pred;
  int                          fail_cnt;

  function automatic csfp_pkg::result_t parse_byte(input logic [7:0] b);
    csfp_pkg::result_t         r;
    logic [csfp_pkg::PosW-1:0] at;
    r  = '0;
    at = frame_pos;
    if (at > csfp_pkg::PosCheck) at = csfp_pkg::PosHunt;
    if (at == csfp_pkg::PosHunt) begin
      if (b == csfp_pkg::SyncFirst) begin
        r.byte_accepted = 1'b1;
        byte_sum        = '0;
        frame_pos       = csfp_pkg::PosSync2;
      end else begin
        frame_pos = csfp_pkg::PosHunt;
      end
    end else if (at == csfp_pkg::PosSync2) begin
      if (b == csfp_pkg::SyncSecond) begin
        r.byte_accepted = 1'b1;
        frame_pos       = csfp_pkg::PosCounter;
      end else begin
        byte_sum  = '0;
        frame_pos = (b == csfp_pkg::SyncFirst) ? csfp_pkg::PosSync2 : csfp_pkg::PosHunt;
      end
    end else if (at <= csfp_pkg::LastPayload) begin
      r.byte_accepted = 1'b1;
      if (at < csfp_pkg::LastPayload || covers_last) byte_sum = byte_sum + b;
      case (at)
        csfp_pkg::PosCounter: seq_counter = b;
        csfp_pkg::PosEnable:  enable_byte = b;
        csfp_pkg::PosPosLo:   target_pos[7:0] = b;
        csfp_pkg::PosPosHi:   target_pos[15:8] = b;
        default:              tail_bytes[int'(at - csfp_pkg::PosTail)] = b;
      endcase
      frame_pos = at + 1'b1;
    end else begin
      if (b == byte_sum) begin
        r.byte_accepted = 1'b1;
        r.frame_done    = 1'b1;
        byte_sum        = '0;
        frame_pos       = csfp_pkg::PosHunt;
      end else begin
        byte_sum  = '0;
        frame_pos = (b == csfp_pkg::SyncFirst) ? csfp_pkg::PosSync2 : csfp_pkg::PosHunt;
      end
    end
    r.bytes_needed = csfp_pkg::FrameLen - frame_pos;
    if (r.frame_done) begin
      r.frame_counter   = seq_counter;
      r.drive_enable    = (enable_byte == csfp_pkg::EnableOn);
      r.target_position = target_pos;
      r.extra_byte6     = tail_bytes[0];
      r.extra_byte7     = tail_bytes[1];
      r.extra_byte8     = tail_bytes[2];
      r.extra_byte9     = tail_bytes[3];
      r.extra_byte10    = tail_bytes[4];
      r.extra_byte11    = tail_bytes[5];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      covers_last = 1'b0;
      frame_pos   = csfp_pkg::PosHunt;
      byte_sum    = '0;
      seq_counter = '0;
      enable_byte = '0;
      target_pos  = '0;
      for (int i = 0; i < csfp_pkg::TailDepth; i++) tail_bytes[i] = '0;
      exp_wr       = '0;
      exp_rd       = '0;
      exp_count    = 0;
      fail_cnt     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {byte_accepted_i, frame_done_i, bytes_needed_i, frame_counter_i,
               drive_enable_i, target_position_i, extra_byte6_i, extra_byte7_i,
               extra_byte8_i, extra_byte9_i, extra_byte10_i, extra_byte11_i};
        if (exp_count == 0) begin
          if (fail_cnt < 10) $display("%0t: result transfer with none expected", $realtime);
          fail_cnt++;
        end else begin
          want      = expected_mem[exp_rd];
          exp_rd    = exp_rd + 4'd1;
          exp_count = exp_count - 1;
          if (got.byte_accepted   !== want.byte_accepted   ||
              got.frame_done      !== want.frame_done      ||
              got.bytes_needed    !== want.bytes_needed    ||
              got.frame_counter   !== want.frame_counter   ||
              got.drive_enable    !== want.drive_enable    ||
              got.target_position !== want.target_position ||
              got.extra_byte6     !== want.extra_byte6     ||
              got.extra_byte7     !== want.extra_byte7     ||
              got.extra_byte8     !== want.extra_byte8     ||
              got.extra_byte9     !== want.extra_byte9     ||
              got.extra_byte10    !== want.extra_byte10    ||
              got.extra_byte11    !== want.extra_byte11) begin
            if (fail_cnt < 10) begin
              $display("%0t: mismatch acc/done/need/cnt/en/pos/tail", $realtime);
              $display("  expected %0d %0d %0d %02h %0d %04h %02h%02h%02h%02h%02h%02h",
                       want.byte_accepted, want.frame_done, want.bytes_needed,
                       want.frame_counter, want.drive_enable, want.target_position,
                       want.extra_byte6, want.extra_byte7, want.extra_byte8,
                       want.extra_byte9, want.extra_byte10, want.extra_byte11);
              $display("  actual   %0d %0d %0d %02h %0d %04h %02h%02h%02h%02h%02h%02h",
                       got.byte_accepted, got.frame_done, got.bytes_needed,
                       got.frame_counter, got.drive_enable, got.target_position,
                       got.extra_byte6, got.extra_byte7, got.extra_byte8,
                       got.extra_byte9, got.extra_byte10, got.extra_byte11);
            end
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pred = parse_byte(rx_byte_i);
        if (exp_count == ExpDepth) begin
          if (fail_cnt < 10) $display("%0t: too many results outstanding", $realtime);
          fail_cnt++;
        end else begin
          expected_mem[exp_wr] = pred;
          exp_wr               = exp_wr + 4'd1;
          exp_count            = exp_count + 1;
        end
      end
      if (cfg_we_i) covers_last = cfg_wdata_i;
      fail_count_o <= fail_cnt;
      pending_o    <= exp_count;
    end
  end

endmodule

// File: bench/sync_checksum_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_checksum_frame_parser_tb
// Drives byte streams into the frame parser: a few directed bytes and frames
// covering sync rejection, resynchronisation and both checksum ranges, then
// random phases of good, corrupted and broken frames mixed with noise, with
// the checksum range changed between phases. Both sides idle at random and
// the receiver holds off once for a long stretch. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------

module sync_checksum_frame_parser_tb;

  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 150;
  localparam int HoldOffCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_stall_i = 1'b0;
  wire         in_stall_o;
  wire         out_valid_o;
  wire         byte_accepted_o;
  wire         frame_done_o;
  wire  [3:0]  bytes_needed_o;
  wire  [7:0]  frame_counter_o;
  wire         drive_enable_o;
  wire  [15:0] target_position_o;
  wire  [7:0]  extra_byte6_o;
  wire  [7:0]  extra_byte7_o;
  wire  [7:0]  extra_byte8_o;
  wire  [7:0]  extra_byte9_o;
  wire  [7:0]  extra_byte10_o;
  wire  [7:0]  extra_byte11_o;

  int          fail_count;
  int          pending;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  logic        cfg_covers = 1'b0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  always #6 clk_i = ~clk_i;

  sync_checksum_frame_parser uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .byte_accepted_o   (byte_accepted_o),
    .frame_done_o      (frame_done_o),
    .bytes_needed_o    (bytes_needed_o),
    .frame_counter_o   (frame_counter_o),
    .drive_enable_o    (drive_enable_o),
    .target_position_o (target_position_o),
    .extra_byte6_o     (extra_byte6_o),
    .extra_byte7_o     (extra_byte7_o),
    .extra_byte8_o     (extra_byte8_o),
    .extra_byte9_o     (extra_byte9_o),
    .extra_byte10_o    (extra_byte10_o),
    .extra_byte11_o    (extra_byte11_o)
  );

  sync_checksum_frame_parser_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .byte_accepted_i   (byte_accepted_o),
    .frame_done_i      (frame_done_o),
    .bytes_needed_i    (bytes_needed_o),
    .frame_counter_i   (frame_counter_o),
    .drive_enable_i    (drive_enable_o),
    .target_position_i (target_position_o),
    .extra_byte6_i     (extra_byte6_o),
    .extra_byte7_i     (extra_byte7_o),
    .extra_byte8_i     (extra_byte8_o),
    .extra_byte9_i     (extra_byte9_o),
    .extra_byte10_i    (extra_byte10_o),
    .extra_byte11_i    (extra_byte11_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 59) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // flaw: 0 good checksum, 1 wrong checksum, 2 wrong checksum equal to the first sync
  task automatic send_frame(input logic [79:0] payload, input int flaw);
    logic [7:0] sum;
    logic [7:0] chk;
    sum = '0;
    for (int i = 0; i < 10; i++) begin
      if (i < 9 || cfg_covers) sum = sum + payload[8*i +: 8];
    end
    if (flaw == 0) chk = sum;
    else if (flaw == 1 || sum == csfp_pkg::SyncFirst) chk = sum + 8'($urandom_range(1, 255));
    else chk = csfp_pkg::SyncFirst;
    send_byte(csfp_pkg::SyncFirst);
    send_byte(csfp_pkg::SyncSecond);
    for (int i = 0; i < 10; i++) send_byte(payload[8*i +: 8]);
    send_byte(chk);
  endtask

  task automatic send_sequence();
    int          kind;
    logic [79:0] payload;
    logic [7:0]  b;
    kind    = $urandom_range(0, 9);
    payload = {$urandom(), $urandom(), 16'($urandom())};
    if ($urandom_range(0, 1) == 1) payload[15:8] = csfp_pkg::EnableOn;
    if ($urandom_range(0, 19) == 0) payload = '0;
    else if ($urandom_range(0, 19) == 0) payload = '1;
    if (kind <= 5) begin
      send_frame(payload, 0);
    end else if (kind <= 7) begin
      send_frame(payload, kind - 5);
    end else if (kind == 8) begin
      send_byte(csfp_pkg::SyncFirst);
      b = 8'($urandom());
      if (b == csfp_pkg::SyncSecond || $urandom_range(0, 2) == 0) b = csfp_pkg::SyncFirst;
      send_byte(b);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
    end
  endtask

  task automatic write_cfg(input logic v);
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_covers  = v;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int n;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == 400) n = HoldOffCycles;
      else if (rx_burst) n = 0;
      else n = $urandom_range(0, 3);
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : byte_source
    logic [79:0] payload;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_cfg(1'b0);
    send_byte(8'h00);
    send_byte(csfp_pkg::SyncFirst);
    send_byte(csfp_pkg::SyncFirst);
    send_byte(8'h00);
    payload        = '1;
    payload[15:8]  = csfp_pkg::EnableOn;
    send_frame(payload, 0);
    drain();
    write_cfg(1'b1);
    send_frame('0, 2);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg((ph % 2) == 0);
      while (bytes_sent < 30 + PhaseItems * (ph + 1)) send_sequence();
      // leave a frame open across the register write
      if (ph % 2 == 1) begin
        send_byte(csfp_pkg::SyncFirst);
        send_byte(csfp_pkg::SyncSecond);
        repeat ($urandom_range(1, 9)) send_byte(8'($urandom()));
      end
      drain();
    end

    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
